[hw/rtl/slh_pkg.sv]
// shared constants, types and controller/datapath interface structs
package slh_pkg;

  localparam int NUM_BINS_DEF    = 2048;
  localparam int MAX_FRAME_BYTES = 1500;
  localparam int HEADER_BYTES    = 40;

  localparam int IP_W     = 32;
  localparam int OPT_W    = 6;
  localparam int PAY_W    = 16;
  localparam int IDX_W    = 11;
  localparam int CNT_W    = 32;
  localparam int SEGT_W   = 6;
  localparam int SEG_W    = 11;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // largest segment payload, before it is reduced by the option bytes
  localparam logic [SEG_W-1:0] SEG_BASE = SEG_W'(MAX_FRAME_BYTES - HEADER_BYTES);

  // register index, taken from the word address
  localparam logic REG_MATCH_IP = 1'b0;

  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [1:0] {
    ADDR_IDX = 2'd0,
    ADDR_SEG = 2'd1,
    ADDR_REM = 2'd2
  } addr_sel_t;

  typedef enum logic [1:0] {
    WR_ZERO = 2'd0,
    WR_FULL = 2'd1,
    WR_ONE  = 2'd2
  } wr_sel_t;

  typedef struct packed {
    logic      load;
    logic      step;
    addr_sel_t rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    logic      emit;
  } slh_cmd_t;

  typedef struct packed {
    logic func;
    logic match;
    logic can_step;
    logic has_full;
    logic has_rem;
    logic clear_last;
  } slh_stat_t;

endpackage

[hw/rtl/segment_length_histogram.sv]
// top level of the segment length histogram with its register port
//
//   channel  direction  handshake           payload
//   in_      in         start / busy        func, source_ip, option_length,
//                                           payload_length, bin_index
//   out_     out        out_valid strobe    bin_count, matched, segment_total
//   cfg_     in/out     apb psel/penable    match_source_ip at byte address 0
//
// a read item passes through decode, the bin read and done before its strobe
// a matching count item passes through decode, the segment divider (one cycle per subtraction),
// the full-segment and remainder bin updates and done before its strobe
// each bin update is a read then a write through the single write port of the bin ram
// after reset busy stays high while the clearing pass zeroes the bins
// the result strobe lasts one cycle and cannot be held off; a new item may be
// started in the same cycle as the strobe
module segment_length_histogram import slh_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [IP_W-1:0]   in_source_ip,
  input  logic [OPT_W-1:0]  in_option_length,
  input  logic [PAY_W-1:0]  in_payload_length,
  input  logic [IDX_W-1:0]  in_bin_index,
  // result channel
  output logic              out_valid,
  output logic [CNT_W-1:0]  out_bin_count,
  output logic              out_matched,
  output logic [SEGT_W-1:0] out_segment_total,
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  slh_cmd_t        cmd;
  slh_stat_t       stat;
  logic [IP_W-1:0] match_ip_r;
  logic            reg_sel;

  // register file: one word, address bit 2 picks the register
  assign reg_sel    = (cfg_paddr[2] == REG_MATCH_IP);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? match_ip_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_ip_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      match_ip_r <= cfg_pwdata;
    end
  end

  // controller owns sequencing, datapath owns item state and the bin ram
  slh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  slh_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .match_ip          (match_ip_r),
    .in_func           (in_func),
    .in_source_ip      (in_source_ip),
    .in_option_length  (in_option_length),
    .in_payload_length (in_payload_length),
    .in_bin_index      (in_bin_index),
    .out_valid         (out_valid),
    .out_bin_count     (out_bin_count),
    .out_matched       (out_matched),
    .out_segment_total (out_segment_total)
  );

endmodule

[hw/rtl/slh_ram.sv]
// generic simple dual-port ram, one write port, registered read
module slh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/slh_ctrl.sv]
// sequencer for clearing, segmenting, bin updates and bin reads
module slh_ctrl import slh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  slh_stat_t stat,
  output slh_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_DECODE  = 10'b0000000100,
    S_DIV     = 10'b0000001000,
    S_RD_FULL = 10'b0000010000,
    S_WR_FULL = 10'b0000100000,
    S_RD_REM  = 10'b0001000000,
    S_WR_REM  = 10'b0010000000,
    S_RD_IDX  = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = ADDR_IDX;
    cmd.wr_sel = WR_ZERO;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_ZERO;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.func == FUNC_READ) begin
          state_nxt = S_RD_IDX;
        end else if (stat.match) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        priority if (stat.can_step) begin
          cmd.step = 1'b1;
        end else if (stat.has_full) begin
          state_nxt = S_RD_FULL;
        end else if (stat.has_rem) begin
          state_nxt = S_RD_REM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD_FULL: begin
        cmd.rd_sel = ADDR_SEG;
        state_nxt  = S_WR_FULL;
      end
      S_WR_FULL: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_FULL;
        state_nxt  = stat.has_rem ? S_RD_REM : S_DONE;
      end
      S_RD_REM: begin
        cmd.rd_sel = ADDR_REM;
        state_nxt  = S_WR_REM;
      end
      S_WR_REM: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_ONE;
        state_nxt  = S_DONE;
      end
      S_RD_IDX: begin
        cmd.rd_sel = ADDR_IDX;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

[hw/rtl/slh_dp.sv]
// item registers, segment divider, bin store and result registers
module slh_dp import slh_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  slh_cmd_t          cmd,
  output slh_stat_t         stat,
  input  logic [IP_W-1:0]   match_ip,
  input  logic              in_func,
  input  logic [IP_W-1:0]   in_source_ip,
  input  logic [OPT_W-1:0]  in_option_length,
  input  logic [PAY_W-1:0]  in_payload_length,
  input  logic [IDX_W-1:0]  in_bin_index,
  output logic              out_valid,
  output logic [CNT_W-1:0]  out_bin_count,
  output logic              out_matched,
  output logic [SEGT_W-1:0] out_segment_total
);

  localparam int AW = $clog2(NUM_BINS);

  logic              func_r;
  logic [IP_W-1:0]   src_r;
  logic [IDX_W-1:0]  idx_r;
  logic              idx_ok_r;
  logic [SEG_W-1:0]  seg_r;
  logic [PAY_W-1:0]  left_r;
  logic [SEGT_W-1:0] full_r;
  logic [AW-1:0]     clr_addr_r;

  logic              valid_r;
  logic [CNT_W-1:0]  count_r;
  logic              matched_r;
  logic [SEGT_W-1:0] segt_r;

  logic              hit;
  logic              can_step;
  logic              has_rem;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic [CNT_W-1:0]  rd_data;

  assign hit      = (src_r == match_ip);
  assign can_step = (left_r >= PAY_W'(seg_r));
  assign has_rem  = (left_r != '0);

  assign stat.func       = func_r;
  assign stat.match      = hit;
  assign stat.can_step   = can_step;
  assign stat.has_full   = (full_r != '0);
  assign stat.has_rem    = has_rem;
  assign stat.clear_last = (clr_addr_r == AW'(NUM_BINS - 1));

  // item capture and repeated subtraction of the segment size
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      src_r    <= in_source_ip;
      idx_r    <= in_bin_index;
      idx_ok_r <= (32'(in_bin_index) < 32'(NUM_BINS));
      seg_r    <= SEG_BASE - SEG_W'(in_option_length);
      left_r   <= in_payload_length;
      full_r   <= '0;
    end else if (cmd.step) begin
      left_r <= left_r - PAY_W'(seg_r);
      full_r <= full_r + SEGT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.wr_en && (cmd.wr_sel == WR_ZERO)) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // segment lengths stay below 1461, so NUM_BINS must exceed that; the block does not check it
  always_comb begin
    unique case (cmd.rd_sel)
      ADDR_IDX: rd_addr = idx_ok_r ? AW'(idx_r) : '0;
      ADDR_SEG: rd_addr = AW'(seg_r);
      ADDR_REM: rd_addr = AW'(left_r[SEG_W-1:0]);
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_ZERO: begin
        wr_addr = clr_addr_r;
        wr_data = '0;
      end
      WR_FULL: begin
        wr_addr = AW'(seg_r);
        wr_data = rd_data + CNT_W'(full_r);
      end
      WR_ONE: begin
        wr_addr = AW'(left_r[SEG_W-1:0]);
        wr_data = rd_data + CNT_W'(1);
      end
      default: begin
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  slh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      count_r   <= ((func_r == FUNC_READ) && idx_ok_r) ? rd_data : '0;
      matched_r <= (func_r == FUNC_COUNT) && hit;
      segt_r    <= ((func_r == FUNC_COUNT) && hit) ?
                   (full_r + SEGT_W'(has_rem)) : '0;
    end
  end

  assign out_valid         = valid_r;
  assign out_bin_count     = count_r;
  assign out_matched       = matched_r;
  assign out_segment_total = segt_r;

endmodule

[hw/rtl/slh_checker.sv]
// port-level checks for the segment length histogram, bound to the top level
module slh_checker import slh_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [CNT_W-1:0]  out_bin_count,
  input logic              out_matched,
  input logic [SEGT_W-1:0] out_segment_total
);

  // clearing pass keeps the block busy right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_segs_need_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_matched) |-> (out_segment_total == '0))
    else $error("segments reported for unmatched item");

  a_count_only_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_bin_count != '0)) |-> !out_matched)
    else $error("bin count on a counted packet");

endmodule

bind segment_length_histogram slh_checker u_slh_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_bin_count     (out_bin_count),
  .out_matched       (out_matched),
  .out_segment_total (out_segment_total)
);

[test/testbench.sv]
// self-checking testbench for segment_length_histogram: directed table, random items, apb config
module testbench;
  import slh_pkg::*;

  // watchdog limit in cycles with no accept, result or register access; covers the clearing pass after reset
  localparam int unsigned STALL_LIMIT = 6000;
  // cycles to wait after the last result for anything stray
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned NUM_PHASES = 5;
  // register 0 at byte address 0
  localparam logic [CFG_AW-1:0] MATCH_IP_ADDR = {REG_MATCH_IP, 2'b00};

  // one input item as the block sees it
  typedef struct {
    logic               func;
    logic [IP_W-1:0]    src;
    logic [OPT_W-1:0]   opt;
    logic [PAY_W-1:0]   payload;
    logic [IDX_W-1:0]   idx;
  } pkt_item_t;

  // one result item
  typedef struct {
    logic [CNT_W-1:0]   bin_count;
    logic               matched;
    logic [SEGT_W-1:0]  segment_total;
  } bin_report_t;

  // directed row: typed-in result only used when fixed is set
  typedef struct {
    pkt_item_t   item;
    bit          fixed;
    bin_report_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_func = FUNC_COUNT;
  logic [IP_W-1:0]   in_source_ip = '0;
  logic [OPT_W-1:0]  in_option_length = '0;
  logic [PAY_W-1:0]  in_payload_length = '0;
  logic [IDX_W-1:0]  in_bin_index = '0;
  logic              out_valid;
  logic [CNT_W-1:0]  out_bin_count;
  logic              out_matched;
  logic [SEGT_W-1:0] out_segment_total;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow copy of the histogram and the source filter
  logic [CNT_W-1:0]  shadow_bins [NUM_BINS_DEF];
  logic [IP_W-1:0]   shadow_match_ip = '0;
  // recently bumped bins, so random reads often hit nonzero counts
  logic [IDX_W-1:0]  recent_bins [$];
  // results still owed by the block, oldest first
  bin_report_t       bin_reports_due [$];

  int unsigned       fail_count = 0;
  int unsigned       idle_cycles = 0;
  stim_row_t         directed_rows [22];

  segment_length_histogram dut (.*);

  // 4 time unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    fail_count++;
  endtask

  // one bin increment, segment lengths past the store are dropped
  function automatic void bump_bin(int unsigned len);
    if (len < NUM_BINS_DEF) begin
      shadow_bins[len] = shadow_bins[len] + 1'b1;
      recent_bins.push_back(IDX_W'(len));
      if (recent_bins.size() > 32) void'(recent_bins.pop_front());
    end
  endfunction

  // predictor: applies one item to the shadow histogram and returns its result
  function automatic bin_report_t apply_item(pkt_item_t it);
    bin_report_t r;
    int unsigned seg_size;
    int unsigned left;
    r.bin_count = '0;
    r.matched = 1'b0;
    r.segment_total = '0;
    if (it.func == FUNC_READ) begin
      if (it.idx < NUM_BINS_DEF) r.bin_count = shadow_bins[it.idx];
    end else if (it.src == shadow_match_ip) begin
      // full segments first, then the nonzero remainder
      seg_size = MAX_FRAME_BYTES - HEADER_BYTES - it.opt;
      left = it.payload;
      r.matched = 1'b1;
      while (left > seg_size) begin
        bump_bin(seg_size);
        left -= seg_size;
        r.segment_total++;
      end
      if (left > 0) begin
        bump_bin(left);
        r.segment_total++;
      end
    end
    return r;
  endfunction

  // random item, shaped so most counted packets match and payloads sit near segment edges
  function automatic pkt_item_t random_item();
    pkt_item_t it;
    int unsigned pick;
    int unsigned seg;
    int unsigned len;
    it.func = FUNC_COUNT;
    it.src = $urandom;
    it.opt = OPT_W'($urandom_range(0, 63));
    it.payload = PAY_W'($urandom);
    it.idx = IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.func = FUNC_READ;
      if (recent_bins.size() != 0 && $urandom_range(0, 1) == 1)
        it.idx = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
    end else begin
      // source: mostly the filter address, some one-bit misses, some random
      pick = $urandom_range(0, 9);
      if (pick < 6) it.src = shadow_match_ip;
      else if (pick < 8) it.src = shadow_match_ip ^ (32'h1 << $urandom_range(0, 31));
      // payload size mix
      pick = $urandom_range(0, 99);
      seg = MAX_FRAME_BYTES - HEADER_BYTES - it.opt;
      if (pick < 10) begin
        it.payload = '0;
      end else if (pick < 50) begin
        it.payload = PAY_W'($urandom_range(1, 3000));
      end else if (pick < 65) begin
        // one below, on, or one above a multiple of the segment size
        len = $urandom_range(1, 46) * seg + $urandom_range(0, 2) - 1;
        if (len > 65535) len = 65535;
        it.payload = PAY_W'(len);
      end else if (pick < 90) begin
        it.payload = PAY_W'($urandom_range(0, 65535));
      end else begin
        it.payload = PAY_W'(65535 - $urandom_range(0, 1500));
      end
    end
    return it;
  endfunction

  // drives one item and holds it until accepted, then records its result
  task automatic send_item(pkt_item_t it, bit fixed, bin_report_t want);
    bin_report_t predicted;
    in_func <= it.func;
    in_source_ip <= it.src;
    in_option_length <= it.opt;
    in_payload_length <= it.payload;
    in_bin_index <= it.idx;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    // accepted at this edge; state always advances through the predictor
    predicted = apply_item(it);
    bin_reports_due.push_back(fixed ? want : predicted);
  endtask

  // lower start and wait for every owed result
  task automatic wait_drained();
    start <= 1'b0;
    while (bin_reports_due.size() != 0) @(posedge clk);
  endtask

  // apb write of the filter address, then read it back
  task automatic set_match_ip(logic [IP_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= MATCH_IP_ADDR;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    shadow_match_ip = value;
    // read phase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== shadow_match_ip)
      report_mismatch("match_source_ip readback", cfg_prdata, shadow_match_ip);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result checker: every strobe is compared with the oldest owed result
  always @(posedge clk) begin
    bin_report_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (bin_reports_due.size() == 0) begin
        report_mismatch("result with no item waiting", out_bin_count, '0);
      end else begin
        want = bin_reports_due.pop_front();
        if (out_bin_count !== want.bin_count)
          report_mismatch("bin_count", out_bin_count, want.bin_count);
        if (out_matched !== want.matched)
          report_mismatch("matched", 32'(out_matched), 32'(want.matched));
        if (out_segment_total !== want.segment_total)
          report_mismatch("segment_total", 32'(out_segment_total), 32'(want.segment_total));
      end
    end
  end

  // watchdog: any accepted item, result or register access restarts the count
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [IP_W-1:0] phase_ip [NUM_PHASES];
    bin_report_t     no_want;
    bit              idling_on;

    foreach (shadow_bins[i]) shadow_bins[i] = '0;
    no_want = '{'0, 1'b0, '0};

    // filter values per random phase, both extremes among them
    phase_ip[0] = 32'hFFFF_FFFF;
    phase_ip[1] = $urandom;
    phase_ip[2] = 32'h0000_0000;
    phase_ip[3] = $urandom;
    phase_ip[4] = 32'hC0A8_0101;

    // directed table, run with the filter at zero
    //                  func        src           opt  payload    idx       fixed  result
    directed_rows[0]  = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd0},    1, '{32'd0, 1'b0, 6'd0}};
    directed_rows[1]  = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd2047}, 1, '{32'd0, 1'b0, 6'd0}};
    // empty payload that matches
    directed_rows[2]  = '{'{FUNC_COUNT, 32'h0,        6'd0,  16'd0,     11'd0},    1, '{32'd0, 1'b1, 6'd0}};
    // no match, all fields at their top
    directed_rows[3]  = '{'{FUNC_COUNT, 32'hFFFFFFFF, 6'd63, 16'hFFFF,  11'd2047}, 1, '{32'd0, 1'b0, 6'd0}};
    directed_rows[4]  = '{'{FUNC_COUNT, 32'h0,        6'd0,  16'd1,     11'd0},    1, '{32'd0, 1'b1, 6'd1}};
    directed_rows[5]  = '{'{FUNC_COUNT, 32'h0,        6'd0,  16'd1460,  11'd0},    1, '{32'd0, 1'b1, 6'd1}};
    directed_rows[6]  = '{'{FUNC_COUNT, 32'h0,        6'd0,  16'd1461,  11'd0},    1, '{32'd0, 1'b1, 6'd2}};
    // jumbo payload with the largest option length gives the most segments
    directed_rows[7]  = '{'{FUNC_COUNT, 32'h0,        6'd63, 16'hFFFF,  11'd0},    1, '{32'd0, 1'b1, 6'd47}};
    directed_rows[8]  = '{'{FUNC_COUNT, 32'h0,        6'd0,  16'hFFFF,  11'd0},    0, no_want};
    directed_rows[9]  = '{'{FUNC_COUNT, 32'h0,        6'd40, 16'd2840,  11'd0},    0, no_want};
    // option length above forty
    directed_rows[10] = '{'{FUNC_COUNT, 32'h0,        6'd41, 16'd1419,  11'd0},    0, no_want};
    directed_rows[11] = '{'{FUNC_COUNT, 32'h1,        6'd0,  16'd100,   11'd0},    1, '{32'd0, 1'b0, 6'd0}};
    directed_rows[12] = '{'{FUNC_COUNT, 32'h80000000, 6'd0,  16'd100,   11'd0},    1, '{32'd0, 1'b0, 6'd0}};
    directed_rows[13] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd1},    0, no_want};
    directed_rows[14] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd1460}, 0, no_want};
    directed_rows[15] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd1397}, 0, no_want};
    directed_rows[16] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd1420}, 0, no_want};
    directed_rows[17] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd1419}, 0, no_want};
    directed_rows[18] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd1273}, 0, no_want};
    directed_rows[19] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'd1295}, 0, no_want};
    directed_rows[20] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'h555},  0, no_want};
    directed_rows[21] = '{'{FUNC_READ,  32'h0,        6'd0,  16'd0,     11'h2AA},  0, no_want};

    // reset held once at the start, never again
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // filter written explicitly once, even at its reset value
    set_match_ip(32'h0);
    foreach (directed_rows[r])
      send_item(directed_rows[r].item, directed_rows[r].fixed, directed_rows[r].want);
    wait_drained();

    // random phases, each with its own filter value
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_match_ip(phase_ip[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_item(), 1'b0, no_want);
        // alternate stretches with and without sender gaps; none in the last phase
        idling_on = (p < NUM_PHASES - 1) && (((n / 25) % 2) == (p % 2));
        if (n == ITEMS_PER_PHASE - 1 || (p == 2 && n == ITEMS_PER_PHASE / 2)) begin
          // phase end, and once mid-phase: hold off until everything is back
          wait_drained();
        end else if (idling_on && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
      end
    end

    // catch anything stray after the last result
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && bin_reports_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/slh_pkg.sv
hw/rtl/slh_ram.sv
hw/rtl/slh_ctrl.sv
hw/rtl/slh_dp.sv
hw/rtl/segment_length_histogram.sv
hw/rtl/slh_checker.sv
test/testbench.sv
